// ----- hdl/round_robin_slot_scheduler_macros.svh -----
// Assertion macros used by the scheduler back end.
`ifndef ROUND_ROBIN_SLOT_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_SLOT_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

// A condition that holds at every clock edge out of reset.
`define RRSS_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("scheduler assertion failed");

// A trigger that implies a consequence in the next cycle.
`define RRSS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("scheduler assertion failed");

`else

`define RRSS_ASSERT_ALWAYS(label, cond)
`define RRSS_ASSERT_NEXT(label, pre, post)

`endif

`endif

// ----- hdl/rrss_pkg.sv -----
// Types and constants of the round-robin slot scheduler.
package rrss_pkg;

	localparam int SLOT_COUNT_DEF        = 6;
	localparam int QUANTUM_BITS_DEF      = 8;
	localparam int QUEUE_DEPTH           = 2;
	localparam int DEFAULT_QUANTUM_RESET = 1;
	localparam int ADDR_BITS             = 3;

	// Register index, taken from paddr[2].
	localparam logic REG_DEFAULT_QUANTUM = 1'b0;

	typedef enum logic [2:0] {
		ACT_TICK   = 3'd0,
		ACT_START  = 3'd1,
		ACT_PAUSE  = 3'd2,
		ACT_RESUME = 3'd3,
		ACT_REMOVE = 3'd4,
		ACT_SETQ   = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_REFUSED = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	// Classified command, as the front end hands it to the back end.
	typedef enum logic [2:0] {
		OP_TICK,
		OP_START,
		OP_PAUSE,
		OP_RESUME,
		OP_REMOVE,
		OP_SETQ,
		OP_BAD,
		OP_RANGE
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_HOLD
	} back_state_t;

	typedef struct packed {
		logic [2:0] action;
		logic [2:0] slot;
		logic [7:0] quantum_ticks;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic       running_valid;
		logic [2:0] running_slot;
		logic [7:0] ticks_left;
	} res_word_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] slot;
		logic [7:0] quantum_ticks;
	} cmd_t;

endpackage

// ----- hdl/rrss_front.sv -----
// Front end: classifies incoming words and queues them for the back end.
module rrss_front #(
	parameter int SLOT_COUNT = rrss_pkg::SLOT_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  rrss_pkg::cmd_word_t cmd_word,
	output logic               q_valid,
	output rrss_pkg::cmd_t     q_word,
	input  logic               q_take
);

	localparam int DEPTH = rrss_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	rrss_pkg::cmd_t cls;
	rrss_pkg::cmd_t queue_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;
	logic           out_of_range;

	always_comb begin
		out_of_range      = (32'(cmd_word.slot) >= 32'(SLOT_COUNT));
		cls.slot          = cmd_word.slot;
		cls.quantum_ticks = cmd_word.quantum_ticks;
		unique case (cmd_word.action)
			rrss_pkg::ACT_TICK:   cls.op = rrss_pkg::OP_TICK;
			rrss_pkg::ACT_START:  cls.op = rrss_pkg::OP_START;
			rrss_pkg::ACT_PAUSE:  cls.op = rrss_pkg::OP_PAUSE;
			rrss_pkg::ACT_RESUME: cls.op = rrss_pkg::OP_RESUME;
			rrss_pkg::ACT_REMOVE: cls.op = rrss_pkg::OP_REMOVE;
			rrss_pkg::ACT_SETQ:   cls.op = rrss_pkg::OP_SETQ;
			default:              cls.op = rrss_pkg::OP_BAD;
		endcase
		// The slot field only matters for real commands.
		if (cls.op != rrss_pkg::OP_TICK && cls.op != rrss_pkg::OP_BAD && out_of_range) begin
			cls.op = rrss_pkg::OP_RANGE;
		end
	end

	assign cmd_stall = (count_q == CW'(DEPTH));
	assign push      = cmd_valid && !cmd_stall;
	assign q_valid   = (count_q != '0);
	assign pop       = q_take && q_valid;
	assign q_word    = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/rrss_back.sv -----
// Back end: applies commands to the slot table, runs the round-robin search, holds the result.
`include "round_robin_slot_scheduler_macros.svh"

module rrss_back #(
	parameter int SLOT_COUNT   = rrss_pkg::SLOT_COUNT_DEF,
	parameter int QUANTUM_BITS = rrss_pkg::QUANTUM_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [QUANTUM_BITS-1:0] default_quantum,
	input  logic                    q_valid,
	input  rrss_pkg::cmd_t          q_word,
	output logic                    q_take,
	output logic                    res_valid,
	input  logic                    res_stall,
	output rrss_pkg::res_word_t     res_word
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int QB = QUANTUM_BITS;

	rrss_pkg::back_state_t state_q, state_d;

	// A slot is inactive when neither flag is set.
	logic [SLOT_COUNT-1:0] active_q, active_d;
	logic [SLOT_COUNT-1:0] paused_q, paused_d;

	logic [QB-1:0] quant_q [SLOT_COUNT];
	logic          quant_we;
	logic [QB-1:0] quant_wdata;

	logic          cur_valid_q, cur_valid_d;
	logic [SW-1:0] cur_slot_q, cur_slot_d;
	logic [QB-1:0] rem_q, rem_d;
	logic [SW-1:0] pos_q, pos_d;
	logic [SW-1:0] cnt_q, cnt_d;
	logic [SW-1:0] cs;
	logic [SW-1:0] nxt;

	rrss_pkg::status_t   status_q, status_d;
	logic                res_valid_q, res_valid_d;
	rrss_pkg::res_word_t res_word_q, res_word_d;

	assign cs       = SW'(q_word.slot);
	assign nxt      = (pos_q == SW'(SLOT_COUNT - 1)) ? '0 : pos_q + 1'b1;
	assign q_take   = (state_q == rrss_pkg::BK_IDLE) && q_valid;
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	always_comb begin
		state_d     = state_q;
		active_d    = active_q;
		paused_d    = paused_q;
		quant_we    = 1'b0;
		quant_wdata = default_quantum;
		cur_valid_d = cur_valid_q;
		cur_slot_d  = cur_slot_q;
		rem_d       = rem_q;
		pos_d       = pos_q;
		cnt_d       = cnt_q;
		status_d    = status_q;
		res_valid_d = res_valid_q && res_stall;
		res_word_d  = res_word_q;

		unique case (state_q)
			rrss_pkg::BK_IDLE: begin
				if (q_valid) begin
					status_d = rrss_pkg::ST_DONE;
					unique case (q_word.op)
						rrss_pkg::OP_TICK: begin
							if (cur_valid_q && rem_q != '0) begin
								rem_d = rem_q - 1'b1;
							end
						end
						rrss_pkg::OP_START: begin
							if (!active_q[cs] && !paused_q[cs]) begin
								active_d[cs] = 1'b1;
								quant_we     = 1'b1;
							end else begin
								status_d = rrss_pkg::ST_REFUSED;
							end
						end
						rrss_pkg::OP_PAUSE: begin
							if (active_q[cs]) begin
								active_d[cs] = 1'b0;
								paused_d[cs] = 1'b1;
							end else begin
								status_d = rrss_pkg::ST_REFUSED;
							end
						end
						rrss_pkg::OP_RESUME: begin
							if (paused_q[cs]) begin
								active_d[cs] = 1'b1;
								paused_d[cs] = 1'b0;
							end else begin
								status_d = rrss_pkg::ST_REFUSED;
							end
						end
						rrss_pkg::OP_REMOVE: begin
							// The running slot keeps its slice even when removed.
							if (active_q[cs] || paused_q[cs]) begin
								active_d[cs] = 1'b0;
								paused_d[cs] = 1'b0;
							end else begin
								status_d = rrss_pkg::ST_REFUSED;
							end
						end
						rrss_pkg::OP_SETQ: begin
							if (active_q[cs]) begin
								quant_we    = 1'b1;
								quant_wdata = QB'(q_word.quantum_ticks);
							end else begin
								status_d = rrss_pkg::ST_REFUSED;
							end
						end
						rrss_pkg::OP_BAD:   status_d = rrss_pkg::ST_REFUSED;
						rrss_pkg::OP_RANGE: status_d = rrss_pkg::ST_RANGE;
					endcase
					if (!cur_valid_q || rem_d == '0) begin
						// With nothing running the search starts at slot zero.
						state_d = rrss_pkg::BK_SEARCH;
						pos_d   = cur_valid_q ? cur_slot_q : SW'(SLOT_COUNT - 1);
						cnt_d   = '0;
					end else begin
						state_d = rrss_pkg::BK_HOLD;
					end
				end
			end
			rrss_pkg::BK_SEARCH: begin
				if (active_q[nxt]) begin
					cur_valid_d = 1'b1;
					cur_slot_d  = nxt;
					rem_d       = quant_q[nxt];
					state_d     = rrss_pkg::BK_HOLD;
				end else if (cnt_q == SW'(SLOT_COUNT - 1)) begin
					cur_valid_d = 1'b0;
					cur_slot_d  = '0;
					rem_d       = '0;
					state_d     = rrss_pkg::BK_HOLD;
				end else begin
					pos_d = nxt;
					cnt_d = cnt_q + 1'b1;
				end
			end
			rrss_pkg::BK_HOLD: begin
				if (!res_valid_q || !res_stall) begin
					res_valid_d                = 1'b1;
					res_word_d.status          = status_q;
					res_word_d.running_valid   = cur_valid_q;
					res_word_d.running_slot    = cur_valid_q ? 3'(cur_slot_q) : '0;
					res_word_d.ticks_left      = cur_valid_q ? 8'(rem_q) : '0;
					state_d                    = rrss_pkg::BK_IDLE;
				end
			end
			default: state_d = rrss_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (quant_we) begin
			quant_q[cs] <= quant_wdata;
		end
		pos_q      <= pos_d;
		cnt_q      <= cnt_d;
		status_q   <= status_d;
		res_word_q <= res_word_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrss_pkg::BK_IDLE;
			active_q    <= '0;
			paused_q    <= '0;
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
			rem_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			active_q    <= active_d;
			paused_q    <= paused_d;
			cur_valid_q <= cur_valid_d;
			cur_slot_q  <= cur_slot_d;
			rem_q       <= rem_d;
			res_valid_q <= res_valid_d;
		end
	end

	`RRSS_ASSERT_ALWAYS(a_idle_cleared, cur_valid_q || (cur_slot_q == '0 && rem_q == '0))
	`RRSS_ASSERT_ALWAYS(a_slot_in_range, cur_slot_q <= SW'(SLOT_COUNT - 1))
	`RRSS_ASSERT_NEXT(a_pick_loads, state_q == rrss_pkg::BK_SEARCH && active_q[nxt], cur_valid_q && cur_slot_q == $past(nxt) && state_q == rrss_pkg::BK_HOLD)

endmodule

// ----- hdl/round_robin_slot_scheduler.sv -----
// Top level of the round-robin slot scheduler: register port, front end and back end.
//
//  channel   direction  handshake                 word
//  cmd       in         cmd_valid / cmd_stall     action, slot, quantum_ticks
//  res       out        res_valid / res_stall     status, running_valid, running_slot, ticks_left
//  cfg       in         psel / penable / pready   default_quantum at byte address 0
//
// A word without a slot search is applied in the idle state and its result handed over in the
// hold state. A search tests one slot per cycle, and the back end takes no new word until the
// result is handed over; that search loop and a stalled output set the rate.
// Reset is asynchronous: all slots go inactive, nothing runs, the default quantum is one.
// A two-word queue keeps taking commands while a result waits on a stalled output.
module round_robin_slot_scheduler #(
	parameter int SLOT_COUNT   = rrss_pkg::SLOT_COUNT_DEF,
	parameter int QUANTUM_BITS = rrss_pkg::QUANTUM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  rrss_pkg::cmd_word_t           cmd_word,
	output logic                          res_valid,
	input  logic                          res_stall,
	output rrss_pkg::res_word_t           res_word,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rrss_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [QUANTUM_BITS-1:0] default_quantum_q;
	logic                    q_valid;
	rrss_pkg::cmd_t          q_word;
	logic                    q_take;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == rrss_pkg::REG_DEFAULT_QUANTUM) ? 32'(default_quantum_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_quantum_q <= QUANTUM_BITS'(rrss_pkg::DEFAULT_QUANTUM_RESET);
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == rrss_pkg::REG_DEFAULT_QUANTUM) begin
			default_quantum_q <= QUANTUM_BITS'(pwdata[7:0]);
		end
	end

	rrss_front #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.q_valid   (q_valid),
		.q_word    (q_word),
		.q_take    (q_take)
	);

	rrss_back #(
		.SLOT_COUNT  (SLOT_COUNT),
		.QUANTUM_BITS(QUANTUM_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.default_quantum (default_quantum_q),
		.q_valid         (q_valid),
		.q_word          (q_word),
		.q_take          (q_take),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.res_word        (res_word)
	);

endmodule

// ----- verif/round_robin_slot_scheduler_tb.sv -----
// Self-checking testbench for the round-robin slot scheduler.
`timescale 1ns / 100ps

module round_robin_slot_scheduler_tb;

	localparam int NSLOT = rrss_pkg::SLOT_COUNT_DEF;
	localparam int DRAIN_CYCLES = NSLOT + 12;
	localparam logic [2:0] ACT_UNKNOWN_LO = 3'd6;
	localparam logic [2:0] ACT_UNKNOWN_HI = 3'd7;
	localparam logic [rrss_pkg::ADDR_BITS-1:0] DEFAULT_QUANTUM_ADDR =
		{rrss_pkg::REG_DEFAULT_QUANTUM, 2'b00};

	typedef enum logic [1:0] {
		SLOT_OFF    = 2'd0,
		SLOT_ACTIVE = 2'd1,
		SLOT_PAUSED = 2'd2
	} slot_mode_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	rrss_pkg::cmd_word_t cmd_word;
	logic res_valid;
	logic res_stall;
	rrss_pkg::res_word_t res_word;
	logic psel;
	logic penable;
	logic pwrite;
	logic [rrss_pkg::ADDR_BITS-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// Scheduler state as predicted from the accepted words.
	slot_mode_t mode_m[NSLOT];
	logic [7:0] quantum_m[NSLOT];
	logic [7:0] slice_left;
	logic [2:0] run_slot;
	bit run_on;
	logic [7:0] dflt_quantum;

	rrss_pkg::res_word_t pending_results[$];
	int mismatch_count;
	int cmds_sent;
	int results_seen;
	int status_seen[3];
	int quantum_settings;
	bit gaps_on;
	bit stall_on;

	round_robin_slot_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word(cmd_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Mostly short waits, now and then a long one.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void reset_schedule();
		for (int i = 0; i < NSLOT; i++) begin
			mode_m[i] = SLOT_OFF;
			quantum_m[i] = '0;
		end
		slice_left = '0;
		run_slot = '0;
		run_on = 1'b0;
		dflt_quantum = 8'(rrss_pkg::DEFAULT_QUANTUM_RESET);
	endfunction

	// Applies one word to the predicted state and returns the result it causes.
	function automatic rrss_pkg::res_word_t schedule_step(rrss_pkg::cmd_word_t w);
		rrss_pkg::res_word_t r;
		rrss_pkg::status_t st;
		slot_mode_t m;
		int pos;
		bit found;
		st = rrss_pkg::ST_DONE;
		if (w.action == rrss_pkg::ACT_TICK) begin
			if (run_on && slice_left != 0)
				slice_left--;
		end else if (w.action > rrss_pkg::ACT_SETQ) begin
			st = rrss_pkg::ST_REFUSED;
		end else if (w.slot >= NSLOT) begin
			st = rrss_pkg::ST_RANGE;
		end else begin
			m = mode_m[w.slot];
			case (w.action)
				rrss_pkg::ACT_START: begin
					if (m == SLOT_OFF) begin
						mode_m[w.slot] = SLOT_ACTIVE;
						quantum_m[w.slot] = dflt_quantum;
					end else
						st = rrss_pkg::ST_REFUSED;
				end
				rrss_pkg::ACT_PAUSE: begin
					if (m == SLOT_ACTIVE)
						mode_m[w.slot] = SLOT_PAUSED;
					else
						st = rrss_pkg::ST_REFUSED;
				end
				rrss_pkg::ACT_RESUME: begin
					if (m == SLOT_PAUSED)
						mode_m[w.slot] = SLOT_ACTIVE;
					else
						st = rrss_pkg::ST_REFUSED;
				end
				rrss_pkg::ACT_REMOVE: begin
					if (m != SLOT_OFF)
						mode_m[w.slot] = SLOT_OFF;
					else
						st = rrss_pkg::ST_REFUSED;
				end
				default: begin
					if (m == SLOT_ACTIVE)
						quantum_m[w.slot] = w.quantum_ticks;
					else
						st = rrss_pkg::ST_REFUSED;
				end
			endcase
		end

		// The search ends on the running slot itself after a full lap.
		if (!run_on || slice_left == 0) begin
			pos = run_on ? int'(run_slot) : NSLOT - 1;
			found = 1'b0;
			for (int n = 0; n < NSLOT && !found; n++) begin
				pos = (pos + 1 >= NSLOT) ? 0 : pos + 1;
				if (mode_m[pos] == SLOT_ACTIVE) begin
					found = 1'b1;
					run_slot = 3'(pos);
					slice_left = quantum_m[pos];
				end
			end
			run_on = found;
			if (!found) begin
				run_slot = '0;
				slice_left = '0;
			end
		end

		r.status = st;
		r.running_valid = run_on;
		r.running_slot = run_on ? run_slot : 3'd0;
		r.ticks_left = run_on ? slice_left : 8'd0;
		return r;
	endfunction

	function automatic rrss_pkg::cmd_word_t make_cmd(logic [2:0] act, logic [2:0] slot,
			logic [7:0] qt);
		rrss_pkg::cmd_word_t w;
		w.action = act;
		w.slot = slot;
		w.quantum_ticks = qt;
		return w;
	endfunction

	task automatic send_cmd(rrss_pkg::cmd_word_t w);
		int gap;
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd_word <= w;
		do
			@(posedge clk);
		while (cmd_stall);
		pending_results.push_back(schedule_step(w));
		cmds_sent++;
		gap = gaps_on ? idle_length() : 0;
		if (gap > 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Lets every outstanding word come back and the back end settle.
	task automatic drain();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_default_quantum(logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DEFAULT_QUANTUM_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		dflt_quantum = value[7:0];
		quantum_settings++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		pwdata <= '0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[7:0] !== dflt_quantum) begin
			$display("%0t: default_quantum readback: expected %0d, got %0d",
				$time, dflt_quantum, prdata[7:0]);
			mismatch_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic rrss_pkg::cmd_word_t random_cmd();
		int r;
		logic [2:0] act;
		logic [2:0] slot;
		logic [7:0] qt;
		r = $urandom_range(0, 99);
		if (r < 42)
			act = rrss_pkg::ACT_TICK;
		else if (r < 58)
			act = rrss_pkg::ACT_START;
		else if (r < 66)
			act = rrss_pkg::ACT_PAUSE;
		else if (r < 75)
			act = rrss_pkg::ACT_RESUME;
		else if (r < 84)
			act = rrss_pkg::ACT_REMOVE;
		else if (r < 97)
			act = rrss_pkg::ACT_SETQ;
		else
			act = 3'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
		slot = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, NSLOT - 1)) :
			3'($urandom_range(NSLOT, 7));
		r = $urandom_range(0, 99);
		if (r < 60)
			qt = 8'($urandom_range(1, 6));
		else if (r < 66)
			qt = 8'd0;
		else if (r < 72)
			qt = 8'd255;
		else
			qt = 8'($urandom);
		return make_cmd(act, slot, qt);
	endfunction

	// Tick on an empty scheduler, unknown actions and slots out of range.
	task automatic test_idle_and_errors();
		send_cmd(make_cmd(rrss_pkg::ACT_TICK, 3'd7, 8'd0));
		send_cmd(make_cmd(ACT_UNKNOWN_LO, 3'd0, 8'd1));
		send_cmd(make_cmd(ACT_UNKNOWN_HI, 3'd7, 8'd255));
		send_cmd(make_cmd(rrss_pkg::ACT_START, 3'(NSLOT), 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_PAUSE, 3'd7, 8'd170));
		send_cmd(make_cmd(rrss_pkg::ACT_PAUSE, 3'd0, 8'd85));
		drain();
	endtask

	// Starts, pauses, resumes and removes slots, with zero and full quanta,
	// expiry of a slice and a restart of the slot that holds the slice.
	task automatic test_slot_lifecycle();
		send_cmd(make_cmd(rrss_pkg::ACT_START, 3'd5, 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_START, 3'd0, 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_SETQ, 3'd0, 8'd255));
		send_cmd(make_cmd(rrss_pkg::ACT_SETQ, 3'd5, 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_TICK, 3'd0, 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_START, 3'd0, 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_REMOVE, 3'd0, 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_START, 3'd0, 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_PAUSE, 3'd5, 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_RESUME, 3'd5, 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_REMOVE, 3'd5, 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_REMOVE, 3'd5, 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_RESUME, 3'd0, 8'd0));
		send_cmd(make_cmd(rrss_pkg::ACT_SETQ, 3'd3, 8'd1));
		drain();
	endtask

	// One setting of the default quantum, then a stretch of random words.
	task automatic test_random_phase(logic [31:0] quantum, int count, bit idling);
		write_default_quantum(quantum);
		gaps_on = idling;
		stall_on = idling;
		for (int i = 0; i < count; i++)
			send_cmd(random_cmd());
		drain();
		gaps_on = 1'b1;
		stall_on = 1'b1;
	endtask

	// Result side: free runs of random length, a few long, broken by stalls while stall_on is set.
	initial begin
		int n;
		res_stall = 1'b0;
		forever begin
			n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 12) :
				$urandom_range(40, 150);
			@(negedge clk);
			res_stall <= 1'b0;
			repeat (n - 1) @(negedge clk);
			if (stall_on) begin
				n = idle_length() + 1;
				@(negedge clk);
				res_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		rrss_pkg::res_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: status=%0d valid=%0d slot=%0d ticks=%0d",
					$time, res_word.status, res_word.running_valid,
					res_word.running_slot, res_word.ticks_left);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (want.status <= rrss_pkg::ST_RANGE)
					status_seen[want.status]++;
				if (res_word !== want) begin
					$display({"%0t: result mismatch: expected status=%0d valid=%0d",
						" slot=%0d ticks=%0d, got status=%0d valid=%0d slot=%0d",
						" ticks=%0d"},
						$time, want.status, want.running_valid, want.running_slot,
						want.ticks_left, res_word.status, res_word.running_valid,
						res_word.running_slot, res_word.ticks_left);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatch_count = 0;
		cmds_sent = 0;
		results_seen = 0;
		status_seen = '{0, 0, 0};
		quantum_settings = 0;
		gaps_on = 1'b1;
		stall_on = 1'b1;
		reset_schedule();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_and_errors();
		test_slot_lifecycle();

		// The upper data bits carry noise; the register keeps eight bits.
		test_random_phase(32'd2, 240, 1'b1);
		test_random_phase(32'hA5A5_A5FF, 240, 1'b1);
		test_random_phase(32'h5A5A_5A00, 200, 1'b1);
		test_random_phase(32'd1, 240, 1'b0);
		test_random_phase(32'($urandom_range(1, 8)), 260, 1'b1);
		test_random_phase({24'($urandom), 8'($urandom_range(1, 255))}, 260, 1'b1);

		$display("Covered %0d command words and %0d results over %0d default quantum settings.",
			cmds_sent, results_seen, quantum_settings);
		$display("Statuses seen: %0d done, %0d refused, %0d out of range.",
			status_seen[rrss_pkg::ST_DONE], status_seen[rrss_pkg::ST_REFUSED],
			status_seen[rrss_pkg::ST_RANGE]);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
